// ----- rtl/tafm_pkg.sv -----
`default_nettype none
package tafm_pkg;

  localparam int FRAME_DEPTH      = 64;
  localparam int SLOTS_PER_FRAME  = 64;
  localparam int MAX_CALL_ARGS    = 16;
  localparam int ARG_BUFFER_DEPTH = 64;
  localparam int PROGRAM_DEPTH    = 4096;

  localparam int LVL_W  = $clog2(FRAME_DEPTH);
  localparam int SLOT_W = $clog2(SLOTS_PER_FRAME);
  localparam int ARG_W  = $clog2(MAX_CALL_ARGS);
  localparam int PEND_W = $clog2(ARG_BUFFER_DEPTH);
  localparam int PC_W   = $clog2(PROGRAM_DEPTH);

  localparam logic [4:0] OP_DEFFUNC   = 5'd0;
  localparam logic [4:0] OP_ENDFUNC   = 5'd1;
  localparam logic [4:0] OP_LOADIMM   = 5'd2;
  localparam logic [4:0] OP_ADD       = 5'd3;
  localparam logic [4:0] OP_SUB       = 5'd4;
  localparam logic [4:0] OP_MUL       = 5'd5;
  localparam logic [4:0] OP_DIV       = 5'd6;
  localparam logic [4:0] OP_EQ        = 5'd7;
  localparam logic [4:0] OP_LT        = 5'd8;
  localparam logic [4:0] OP_GT        = 5'd9;
  localparam logic [4:0] OP_STORE     = 5'd10;
  localparam logic [4:0] OP_JMPFALSE  = 5'd11;
  localparam logic [4:0] OP_JMP       = 5'd12;
  localparam logic [4:0] OP_PUSHARG   = 5'd13;
  localparam logic [4:0] OP_CALL      = 5'd14;
  localparam logic [4:0] OP_BINDPARAM = 5'd15;
  localparam logic [4:0] OP_RETURN    = 5'd16;

  localparam logic [2:0] FLT_NONE    = 3'd0;
  localparam logic [2:0] FLT_DIV0    = 3'd1;
  localparam logic [2:0] FLT_FRAME   = 3'd2;
  localparam logic [2:0] FLT_TOP_RET = 3'd3;
  localparam logic [2:0] FLT_ARGS    = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_EXEC, S_DIV, S_COPY, S_RETRD, S_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic rda;
    logic rdb;
    logic exec;
    logic div;
    logic copy;
    logic retrd;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_go;
    logic call_go;
    logic ret_go;
    logic div_done;
    logic copy_last;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/tafm_ram.sv -----
`default_nettype none
module tafm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/tafm_div.sv -----
`default_nettype none
module tafm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic [32:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  assign rem_sh  = {rem[31:0], quotient[31]};
  assign rem_sub = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!rem_sub[32]) begin
        rem      <= rem_sub;
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= rem_sh;
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tafm_ctrl.sv -----
`default_nettype none
module tafm_ctrl
  import tafm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = sts.out_free;
        if (s_tvalid && sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_RDA;
        end
      end
      S_RDA: begin
        cmd.rda    = 1'b1;
        state_next = S_RDB;
      end
      S_RDB: begin
        cmd.rdb    = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.div_go) begin
          state_next = S_DIV;
        end else if (sts.call_go) begin
          state_next = S_COPY;
        end else if (sts.ret_go) begin
          state_next = S_RETRD;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_done) begin
          state_next = S_WRITE;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_last) begin
          state_next = S_WRITE;
        end
      end
      S_RETRD: begin
        cmd.retrd  = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/tafm_dp.sv -----
`default_nettype none
module tafm_dp
  import tafm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [95:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data,
  input  wire cmd_t        cmd,
  output sts_t             sts
);

  localparam int FRM_W = PC_W + SLOT_W + 5;

  logic [12:0]       prog_len;
  logic [PC_W-1:0]   pc;
  logic              skip;
  logic [LVL_W-1:0]  level;
  logic [PEND_W:0]   pend_cnt;

  logic [4:0]        op_q;
  logic [5:0]        dslot_q;
  logic              alit_q, blit_q;
  logic [31:0]       aopd_q, bopd_q;
  logic [11:0]       tgt_q;
  logic [4:0]        nargs_q;

  logic [31:0]       a_val;
  logic [63:0]       row_q;
  logic [FRM_W-1:0]  frm_q;
  logic [4:0]        bind_q;

  logic              wr_q;
  logic [SLOT_W-1:0] wslot_q;
  logic [31:0]       wval_q;
  logic [2:0]        fault_q;
  logic [12:0]       npc_q;
  logic [LVL_W-1:0]  lvl_nx_q;
  logic [PEND_W:0]   pend_nx_q;
  logic              skip_nx_q;
  logic              div_neg_q;
  logic [PEND_W-1:0] cpy_base_q;
  logic [4:0]        cnt_q;

  logic [31:0]       slot_rdata, passed_rdata, pend_rdata, div_q;
  logic [63:0]       marks_raw, marks_row;
  logic [FRM_W-1:0]  frm_rdata;
  logic [4:0]        bind_rdata;
  logic              marks_rvalid;
  logic [FRAME_DEPTH-1:0] row_valid;

  logic [LVL_W+SLOT_W-1:0] slot_raddr;
  logic [LVL_W-1:0]       marks_raddr, marks_waddr;
  logic                   marks_we;
  logic [63:0]            marks_wdata, wrow;
  logic [LVL_W+ARG_W-1:0] passed_waddr, passed_raddr;
  logic [PEND_W-1:0]      pend_raddr;
  logic [4:0]             cnt_m1;

  logic [31:0]      b_val, x_wval, a_mag, b_mag, mul_lo;
  logic             x_wr, x_skip, x_call, x_ret, x_div, x_push, x_bind;
  logic [2:0]       x_fault;
  logic [12:0]      x_npc, pc_inc;
  logic [LVL_W-1:0] x_lvl, lvl_up;
  logic [PEND_W:0]  x_pend;
  logic [4:0]       args_given;

  assign marks_row = marks_rvalid ? marks_raw : '0;
  assign lvl_up    = LVL_W'(level + 1'b1);
  assign pc_inc    = {1'b0, pc} + 13'd1;
  assign cnt_m1    = cnt_q - 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len  <= '0;
      pc        <= '0;
      skip      <= 1'b0;
      level     <= '0;
      pend_cnt  <= '0;
      m_tvalid  <= 1'b0;
      row_valid <= '0;
    end else begin
      if (cfg_wr_en) begin
        prog_len <= cfg_wr_data;
      end
      if (marks_we) begin
        row_valid[marks_waddr] <= 1'b1;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.write) begin
        m_tvalid <= 1'b1;
        pc       <= npc_q[PC_W-1:0];
        level    <= lvl_nx_q;
        pend_cnt <= pend_nx_q;
        skip     <= skip_nx_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    marks_rvalid <= row_valid[marks_raddr];
    if (cmd.load) begin
      op_q    <= s_tdata[4:0];
      dslot_q <= s_tdata[10:5];
      aopd_q  <= s_tdata[42:11];
      bopd_q  <= s_tdata[74:43];
      tgt_q   <= s_tdata[86:75];
      nargs_q <= s_tdata[91:87];
      alit_q  <= s_tuser[0];
      blit_q  <= s_tuser[1];
    end
    if (cmd.rdb) begin
      row_q  <= marks_row;
      a_val  <= alit_q ? aopd_q
                       : (marks_row[aopd_q[SLOT_W-1:0]] ? slot_rdata : '0);
      frm_q  <= frm_rdata;
      bind_q <= bind_rdata;
    end
    if (cmd.exec) begin
      wr_q       <= x_wr;
      wslot_q    <= x_wr ? dslot_q : '0;
      wval_q     <= x_wr ? x_wval : '0;
      fault_q    <= x_fault;
      npc_q      <= x_npc;
      lvl_nx_q   <= x_lvl;
      pend_nx_q  <= x_pend;
      skip_nx_q  <= x_skip;
      div_neg_q  <= a_val[31] ^ b_val[31];
      cpy_base_q <= PEND_W'(pend_cnt - {2'b0, nargs_q});
      cnt_q      <= '0;
      if (x_ret) begin
        wslot_q <= frm_q[PC_W +: SLOT_W];
      end
    end
    if (cmd.div && sts.div_done) begin
      wr_q    <= 1'b1;
      wslot_q <= dslot_q;
      wval_q  <= div_neg_q ? 32'(-div_q) : div_q;
    end
    if (cmd.copy) begin
      cnt_q <= cnt_q + 5'd1;
    end
    if (cmd.write) begin
      m_tdata <= {1'b0, fault_q, wval_q, wslot_q, wr_q,
                  (npc_q >= prog_len), npc_q[PC_W-1:0]};
    end
  end

  always_comb begin
    b_val      = blit_q ? bopd_q
                        : (row_q[bopd_q[SLOT_W-1:0]] ? slot_rdata : '0);
    a_mag      = a_val[31] ? 32'(-a_val) : a_val;
    b_mag      = b_val[31] ? 32'(-b_val) : b_val;
    mul_lo     = a_val * b_val;
    args_given = (level == '0) ? 5'd0 : frm_q[FRM_W-1 -: 5];
    x_wr    = 1'b0;
    x_wval  = '0;
    x_fault = FLT_NONE;
    x_npc   = pc_inc;
    x_lvl   = level;
    x_pend  = pend_cnt;
    x_skip  = skip;
    x_call  = 1'b0;
    x_ret   = 1'b0;
    x_div   = 1'b0;
    x_push  = 1'b0;
    x_bind  = 1'b0;
    if (skip) begin
      if (op_q == OP_ENDFUNC) begin
        x_skip = 1'b0;
      end
    end else begin
      case (op_q)
        OP_DEFFUNC: x_skip = 1'b1;
        OP_LOADIMM: begin
          x_wr   = 1'b1;
          x_wval = aopd_q;
        end
        OP_ADD: begin
          x_wr   = 1'b1;
          x_wval = a_val + b_val;
        end
        OP_SUB: begin
          x_wr   = 1'b1;
          x_wval = a_val - b_val;
        end
        OP_MUL: begin
          x_wr   = 1'b1;
          x_wval = mul_lo;
        end
        OP_DIV: begin
          if (b_val == '0) begin
            x_fault = FLT_DIV0;
          end else begin
            x_div = 1'b1;
          end
        end
        OP_EQ: begin
          x_wr   = 1'b1;
          x_wval = {31'd0, a_val == b_val};
        end
        OP_LT: begin
          x_wr   = 1'b1;
          x_wval = {31'd0, $signed(a_val) < $signed(b_val)};
        end
        OP_GT: begin
          x_wr   = 1'b1;
          x_wval = {31'd0, $signed(b_val) < $signed(a_val)};
        end
        OP_STORE: begin
          x_wr   = 1'b1;
          x_wval = a_val;
        end
        OP_JMPFALSE: begin
          if (a_val == '0) begin
            x_npc = {1'b0, tgt_q};
          end
        end
        OP_JMP: x_npc = {1'b0, tgt_q};
        OP_PUSHARG: begin
          if (pend_cnt >= (PEND_W+1)'(ARG_BUFFER_DEPTH)) begin
            x_fault = FLT_ARGS;
          end else begin
            x_push = 1'b1;
            x_pend = pend_cnt + 1'b1;
          end
        end
        OP_CALL: begin
          if (level == LVL_W'(FRAME_DEPTH - 1)) begin
            x_fault = FLT_FRAME;
          end else if (nargs_q > 5'(MAX_CALL_ARGS) ||
                       {2'b0, nargs_q} > pend_cnt) begin
            x_fault = FLT_ARGS;
          end else begin
            x_call = 1'b1;
            x_npc  = {1'b0, tgt_q};
            x_lvl  = lvl_up;
            x_pend = pend_cnt - {2'b0, nargs_q};
          end
        end
        OP_BINDPARAM: begin
          // top frame never received arguments
          if (level == '0 || bind_q >= args_given || bind_q >= 5'(MAX_CALL_ARGS)) begin
            x_fault = FLT_ARGS;
          end else begin
            x_bind = 1'b1;
            x_wr   = 1'b1;
            x_wval = passed_rdata;
          end
        end
        OP_RETURN: begin
          if (level == '0) begin
            x_fault = FLT_TOP_RET;
          end else begin
            x_ret  = 1'b1;
            x_wr   = 1'b1;
            x_wval = a_val;
            x_npc  = {1'b0, frm_q[PC_W-1:0]};
            x_lvl  = LVL_W'(level - 1'b1);
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.out_free  = !m_tvalid || m_tready;
  assign sts.div_go    = x_div;
  assign sts.call_go   = x_call;
  assign sts.ret_go    = x_ret;
  assign sts.copy_last = (cnt_q == nargs_q);

  assign slot_raddr  = cmd.rda ? {level, aopd_q[SLOT_W-1:0]} : {level, bopd_q[SLOT_W-1:0]};
  assign marks_raddr = cmd.retrd ? LVL_W'(level - 1'b1) : level;
  assign wrow        = (lvl_nx_q != level) ? marks_row : row_q;

  always_comb begin
    marks_we    = 1'b0;
    marks_waddr = lvl_nx_q;
    marks_wdata = wrow | (64'd1 << wslot_q);
    if (cmd.exec && x_call) begin
      marks_we    = 1'b1;
      marks_waddr = lvl_up;
      marks_wdata = '0;
    end else if (cmd.write && wr_q) begin
      marks_we = 1'b1;
    end
  end

  assign passed_raddr = {level, bind_rdata[ARG_W-1:0]};
  assign passed_waddr = {lvl_nx_q, cnt_m1[ARG_W-1:0]};
  assign pend_raddr   = PEND_W'(cpy_base_q + {1'b0, cnt_q});

  tafm_ram #(.WIDTH(32), .DEPTH(FRAME_DEPTH * SLOTS_PER_FRAME)) u_slot_ram (
    .clk(clk), .we(cmd.write && wr_q), .waddr({lvl_nx_q, wslot_q}), .wdata(wval_q),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  tafm_ram #(.WIDTH(64), .DEPTH(FRAME_DEPTH)) u_marks_ram (
    .clk(clk), .we(marks_we), .waddr(marks_waddr), .wdata(marks_wdata),
    .raddr(marks_raddr), .rdata(marks_raw)
  );

  tafm_ram #(.WIDTH(FRM_W), .DEPTH(FRAME_DEPTH)) u_frame_ram (
    .clk(clk), .we(cmd.exec && x_call), .waddr(lvl_up),
    .wdata({nargs_q, dslot_q, pc_inc[PC_W-1:0]}),
    .raddr(level), .rdata(frm_rdata)
  );

  tafm_ram #(.WIDTH(5), .DEPTH(FRAME_DEPTH)) u_bind_ram (
    .clk(clk), .we(cmd.exec && (x_call || x_bind)),
    .waddr(x_call ? lvl_up : level),
    .wdata(x_call ? 5'd0 : 5'(bind_q + 5'd1)),
    .raddr(level), .rdata(bind_rdata)
  );

  tafm_ram #(.WIDTH(32), .DEPTH(FRAME_DEPTH * MAX_CALL_ARGS)) u_passed_ram (
    .clk(clk), .we(cmd.copy && cnt_q != '0), .waddr(passed_waddr), .wdata(pend_rdata),
    .raddr(passed_raddr), .rdata(passed_rdata)
  );

  tafm_ram #(.WIDTH(32), .DEPTH(ARG_BUFFER_DEPTH)) u_pend_ram (
    .clk(clk), .we(cmd.exec && x_push), .waddr(pend_cnt[PEND_W-1:0]), .wdata(a_val),
    .raddr(pend_raddr), .rdata(pend_rdata)
  );

  tafm_div u_div (
    .clk(clk), .rst(rst), .start(cmd.exec && x_div),
    .dividend(a_mag), .divisor(b_mag),
    .done(sts.div_done), .quotient(div_q)
  );

endmodule
`default_nettype wire

// ----- rtl/three_address_frame_machine_core.sv -----
// channel  direction  fields
// s_*      in         tdata: func, dest_slot, a_operand, b_operand, target_addr, arg_count
//                     tuser: a_is_literal, b_is_literal
// m_*      out        tdata: next_pc, done_res, wr_enable, wr_slot, wr_value, fault
// cfg_*    in         program_length
//
// the result is registered through the RDA, RDB, EXEC and WRITE states, plus RETRD for a return
// no new item is taken until the previous one has passed WRITE and returned to IDLE
// divide waits in the DIV state for the shift-subtract divider
// call copies the arguments in the COPY state through one ram port
// synchronous reset; no clearing pass, frame mark rows have per-row valid flags
// a new item is taken once the previous result has left or is leaving
`default_nettype none
module three_address_frame_machine_core
  import tafm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,  // func, dest_slot, a_operand, b_operand, target_addr, arg_count
  input  wire logic [1:0]  s_tuser,  // a_is_literal, b_is_literal
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,  // next_pc, done_res, wr_enable, wr_slot, wr_value, fault
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  tafm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .sts(sts), .cmd(cmd)
  );

  tafm_dp u_dp (
    .clk(clk), .rst(rst), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .cmd(cmd), .sts(sts)
  );

endmodule
`default_nettype wire

// ----- dv/three_address_frame_machine_core_tb.sv -----
`default_nettype none
module three_address_frame_machine_core_tb;
  import tafm_pkg::*;

  localparam logic [4:0] OP_NOP = 5'd17;
  localparam logic [4:0] OP_BAD = 5'd31;

  typedef struct packed {
    logic [2:0]  fault;
    logic [31:0] val;
    logic [5:0]  slot;
    logic        wr;
    logic        done;
    logic [11:0] npc;
  } res_t;

  typedef struct {
    logic [4:0]  op;
    logic [5:0]  dst;
    logic        al;
    logic [31:0] a;
    logic        bl;
    logic [31:0] b;
    logic [11:0] tgt;
    logic [4:0]  n;
    bit          typed;
    res_t        want;
  } instr_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;  // func, dest_slot, a_operand, b_operand, target_addr, arg_count
  logic [1:0]  s_tuser = '0;  // a_is_literal, b_is_literal
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [55:0] m_tdata;      // next_pc, done_res, wr_enable, wr_slot, wr_value, fault
  logic        cfg_wr_en = 0;
  logic [12:0] cfg_wr_data = '0;

  three_address_frame_machine_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // machine state as the predictor sees it
  logic [31:0] slot_val [64][64];
  bit          slot_mark [64][64];
  logic [11:0] ret_pc [64];
  logic [5:0]  ret_slot [64];
  logic [31:0] passed [64][16];
  int          given [64];
  int          bound [64];
  logic [31:0] arg_buf [64];
  int          arg_cnt = 0;
  int          level = 0;
  int          pc = 0;
  bit          skipping = 0;
  int          prog_len = 0;

  res_t results_q[$];
  int   errors = 0;
  int   sent = 0;
  int   burst_left = 0;
  bit   hold_req = 0;
  int   ready_pct = 100;

  function automatic logic [31:0] fetch_operand(logic lit, logic [31:0] v);
    if (lit) return v;
    return slot_mark[level][v[5:0]] ? slot_val[level][v[5:0]] : 32'd0;
  endfunction

  function automatic res_t execute(instr_t t);
    res_t r;
    logic [31:0] x, y, v;
    logic [5:0] d;
    logic [2:0] f;
    int np, nx, i;
    bit wr;
    r = '0; np = pc + 1; wr = 0; v = 0; f = FLT_NONE; d = t.dst;
    if (skipping) begin
      if (t.op == OP_ENDFUNC) skipping = 0;
    end else begin
      x = fetch_operand(t.al, t.a);
      y = fetch_operand(t.bl, t.b);
      case (t.op)
        OP_DEFFUNC: skipping = 1;
        OP_LOADIMM: begin wr = 1; v = t.a; end
        OP_ADD: begin wr = 1; v = x + y; end
        OP_SUB: begin wr = 1; v = x - y; end
        OP_MUL: begin wr = 1; v = x * y; end
        OP_DIV: begin
          if (y == 0) f = FLT_DIV0;
          else begin
            wr = 1;
            if (x == 32'h8000_0000 && y == 32'hffff_ffff) v = x;
            else v = $signed(x) / $signed(y);
          end
        end
        OP_EQ: begin wr = 1; v = (x == y); end
        OP_LT: begin wr = 1; v = ($signed(x) < $signed(y)); end
        OP_GT: begin wr = 1; v = ($signed(y) < $signed(x)); end
        OP_STORE: begin wr = 1; v = x; end
        OP_JMPFALSE: if (x == 0) np = t.tgt;
        OP_JMP: np = t.tgt;
        OP_PUSHARG: begin
          if (arg_cnt >= ARG_BUFFER_DEPTH) f = FLT_ARGS;
          else begin arg_buf[arg_cnt] = x; arg_cnt++; end
        end
        OP_CALL: begin
          if (level + 1 >= FRAME_DEPTH) f = FLT_FRAME;
          else if (t.n > MAX_CALL_ARGS || t.n > arg_cnt) f = FLT_ARGS;
          else begin
            nx = level + 1;
            for (i = 0; i < 64; i++) slot_mark[nx][i] = 0;
            ret_pc[nx] = (pc + 1) % PROGRAM_DEPTH;
            ret_slot[nx] = d;
            given[nx] = t.n;
            bound[nx] = 0;
            for (i = 0; i < t.n; i++) passed[nx][i] = arg_buf[arg_cnt - t.n + i];
            arg_cnt -= t.n;
            level = nx;
            np = t.tgt;
          end
        end
        OP_BINDPARAM: begin
          if (bound[level] >= given[level] || bound[level] >= MAX_CALL_ARGS) f = FLT_ARGS;
          else begin
            wr = 1;
            v = passed[level][bound[level]];
            bound[level]++;
          end
        end
        OP_RETURN: begin
          if (level == 0) f = FLT_TOP_RET;
          else begin
            v = x; np = ret_pc[level]; d = ret_slot[level];
            level--; wr = 1;
          end
        end
        default: ;
      endcase
    end
    if (wr) begin
      slot_val[level][d] = v;
      slot_mark[level][d] = 1;
    end
    pc = np % PROGRAM_DEPTH;
    r.npc = pc;
    r.done = (np >= prog_len);
    r.wr = wr;
    r.slot = wr ? d : 6'd0;
    r.val = wr ? v : 32'd0;
    r.fault = f;
    return r;
  endfunction

  function automatic instr_t ins(logic [4:0] op, logic [5:0] dst, logic al, logic [31:0] a,
                                 logic bl, logic [31:0] b, logic [11:0] tgt, logic [4:0] n);
    instr_t t;
    t.op = op; t.dst = dst; t.al = al; t.a = a; t.bl = bl; t.b = b;
    t.tgt = tgt; t.n = n; t.typed = 0; t.want = '0;
    return t;
  endfunction

  function automatic instr_t known(instr_t t, logic [11:0] npc, logic wr, logic [5:0] slot,
                                   logic [31:0] val, logic [2:0] f);
    t.typed = 1;
    t.want = '{fault: f, val: val, slot: slot, wr: wr, done: 1'b0, npc: npc};
    return t;
  endfunction

  function automatic logic [31:0] rnd_opnd(logic lit);
    if (lit || $urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 63);
  endfunction

  function automatic instr_t rnd_instr(bit wild);
    instr_t t;
    t = ins($urandom_range(2, 17), $urandom_range(0, 63), $urandom_range(0, 1), 0,
            $urandom_range(0, 1), 0, $urandom, $urandom_range(0, 3));
    if (wild) begin
      t.op = $urandom_range(1, 31);
      t.n = $urandom;
    end
    t.a = rnd_opnd(t.al);
    t.b = rnd_opnd(t.bl);
    if (t.op == OP_DIV && $urandom_range(0, 3) == 0) begin
      t.bl = 1; t.b = 0;
    end
    return t;
  endfunction

  task automatic send(instr_t t);
    res_t r;
    bit was_skipping;
    s_tdata <= {4'b0, t.n, t.tgt, t.b, t.a, t.dst, t.op};
    s_tuser <= {t.bl, t.al};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    was_skipping = skipping;
    r = execute(t);
    results_q.push_back(t.typed ? t.want : r);
    if (!was_skipping) sent++;
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
  endtask

  task automatic settle_and_set_length(int len);
    s_tvalid <= 0;
    while (results_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= 13'(len);
    @(posedge clk);
    cfg_wr_en <= 0;
    prog_len = len;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[54:0];
      if (results_q.size() == 0) begin
        report("unexpected item", m_tdata[31:0], 32'd0);
      end else begin
        want = results_q.pop_front();
        if (got.npc !== want.npc) report("next_pc", got.npc, want.npc);
        if (got.done !== want.done) report("done_res", got.done, want.done);
        if (got.wr !== want.wr) report("wr_enable", got.wr, want.wr);
        if (got.slot !== want.slot) report("wr_slot", got.slot, want.slot);
        if (got.val !== want.val) report("wr_value", got.val, want.val);
        if (got.fault !== want.fault) report("fault", got.fault, want.fault);
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int tick;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else begin
        tick++;
        if (tick % 64 == 0) ready_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(20, 90);
        m_tready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    instr_t dir_rows[$];
    int lens[5];
    int ph, k, m, i, quota;
    repeat (11) @(posedge clk);
    rst <= 0;
    burst_left = 5;

    // directed part
    dir_rows.push_back(known(ins(OP_LOADIMM, 1, 1, 32'h7fff_ffff, 0, 0, 0, 0),
                             1, 1, 1, 32'h7fff_ffff, FLT_NONE));
    dir_rows.push_back(known(ins(OP_LOADIMM, 2, 0, 32'h8000_0000, 1, 32'hffff_ffff, 0, 0),
                             2, 1, 2, 32'h8000_0000, FLT_NONE));
    dir_rows.push_back(known(ins(OP_DIV, 6, 1, 5, 1, 0, 0, 0), 3, 0, 0, 0, FLT_DIV0));
    dir_rows.push_back(known(ins(OP_RETURN, 9, 1, 3, 0, 0, 0, 0), 4, 0, 0, 0, FLT_TOP_RET));
    dir_rows.push_back(known(ins(OP_BINDPARAM, 7, 0, 0, 0, 0, 0, 0), 5, 0, 0, 0, FLT_ARGS));
    dir_rows.push_back(ins(OP_LOADIMM, 4, 1, 32'hffff_ffff, 1, 0, 0, 0));
    dir_rows.push_back(ins(OP_ADD, 3, 0, 1, 0, 2, 0, 0));
    dir_rows.push_back(ins(OP_SUB, 8, 0, 2, 1, 1, 0, 0));
    dir_rows.push_back(ins(OP_MUL, 9, 0, 1, 0, 1, 0, 0));
    dir_rows.push_back(ins(OP_DIV, 10, 0, 2, 0, 4, 0, 0));
    dir_rows.push_back(ins(OP_DIV, 11, 1, -7, 1, 2, 0, 0));
    dir_rows.push_back(ins(OP_EQ, 12, 0, 1, 1, 32'h7fff_ffff, 0, 0));
    dir_rows.push_back(ins(OP_LT, 13, 0, 2, 0, 1, 0, 0));
    dir_rows.push_back(ins(OP_GT, 14, 0, 2, 0, 1, 0, 0));
    dir_rows.push_back(ins(OP_STORE, 63, 0, 32'hffff_ffc1, 0, 0, 0, 0));
    dir_rows.push_back(ins(OP_BAD, 5, 1, 0, 1, 0, 12'hfff, 5'h1f));
    dir_rows.push_back(ins(OP_PUSHARG, 0, 1, 32'hdead_beef, 0, 0, 0, 0));
    dir_rows.push_back(ins(OP_PUSHARG, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(ins(OP_CALL, 20, 0, 0, 0, 0, 12'hfff, 2));
    dir_rows.push_back(ins(OP_BINDPARAM, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(ins(OP_BINDPARAM, 33, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(ins(OP_ADD, 2, 0, 0, 0, 33, 0, 0));
    dir_rows.push_back(ins(OP_RETURN, 0, 0, 2, 0, 0, 0, 0));
    dir_rows.push_back(ins(OP_DEFFUNC, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(ins(OP_LOADIMM, 1, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(ins(OP_ENDFUNC, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(ins(OP_JMPFALSE, 0, 0, 50, 0, 0, 100, 0));
    dir_rows.push_back(ins(OP_JMP, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(ins(OP_CALL, 1, 0, 0, 0, 0, 7, 17));
    dir_rows.push_back(ins(OP_NOP, 0, 0, 0, 0, 0, 0, 0));

    settle_and_set_length(20);
    foreach (dir_rows[j]) send(dir_rows[j]);

    // random phases over several program lengths
    lens[0] = 4096; lens[1] = 0; lens[2] = 4095;
    lens[3] = $urandom_range(1, 4096); lens[4] = 37;
    for (ph = 0; ph < 5; ph++) begin
      settle_and_set_length(lens[ph]);
      if (ph == 2) hold_req = 1;
      quota = sent + 205;
      if (ph == 1) begin
        for (i = 0; i < 66; i++) send(ins(OP_PUSHARG, 0, 1, $urandom, 0, 0, 0, 0));
        for (i = 0; i < 4; i++) send(ins(OP_CALL, 0, 0, 0, 0, 0, $urandom, 16));
      end
      if (ph == 3) begin
        for (i = 0; i < 64; i++) send(ins(OP_CALL, $urandom, 0, 0, 0, 0, $urandom, 0));
        for (i = 0; i < 64; i++) send(ins(OP_RETURN, 0, 1, $urandom, 0, 0, 0, 0));
      end
      while (sent < quota) begin
        k = $urandom_range(0, 9);
        case (k)
          0, 1, 2: send(rnd_instr(0));
          3: send(rnd_instr(1));
          4, 5: begin
            m = $urandom_range(0, 4);
            for (i = 0; i < m; i++) send(ins(OP_PUSHARG, 0, $urandom, rnd_opnd(0), 0, 0, 0, 0));
            send(ins(OP_CALL, $urandom, 0, 0, 0, 0, $urandom,
                     ($urandom_range(0, 7) == 0) ? $urandom : m));
            for (i = 0; i < m + $urandom_range(0, 1); i++)
              send(ins(OP_BINDPARAM, $urandom, 0, 0, 0, 0, 0, 0));
            repeat ($urandom_range(1, 3)) send(rnd_instr(0));
            if ($urandom_range(0, 4) != 0)
              send(ins(OP_RETURN, 0, $urandom, rnd_opnd(0), 0, 0, 0, 0));
          end
          6: begin
            send(ins(OP_DEFFUNC, 0, 0, 0, 0, 0, 0, 0));
            repeat ($urandom_range(1, 4)) send(rnd_instr(1));
            send(ins(OP_ENDFUNC, 0, 0, 0, 0, 0, 0, 0));
          end
          7: send(ins(OP_RETURN, 0, $urandom, rnd_opnd(0), 0, 0, 0, 0));
          8: repeat ($urandom_range(1, 6)) send(ins(OP_PUSHARG, 0, 1, $urandom, 0, 0, 0, 0));
          default: send(ins($urandom_range(0, 1) ? OP_JMP : OP_JMPFALSE, 0, $urandom,
                            rnd_opnd(0), 0, 0, $urandom, 0));
        endcase
      end
    end

    s_tvalid <= 0;
    while (results_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/tafm_pkg.sv
rtl/tafm_ram.sv
rtl/tafm_div.sv
rtl/tafm_ctrl.sv
rtl/tafm_dp.sv
rtl/three_address_frame_machine_core.sv
dv/three_address_frame_machine_core_tb.sv
